/* src/ble_mnt_pkg.sv */
// Shared types and constants for the BLE-MIDI note tracker.
package ble_mnt_pkg;

	localparam logic [15:0] TIMEOUT_RST = 16'd5000;
	localparam logic [7:0]  TS_HI_MASK  = 8'h3f;
	localparam logic [7:0]  TS_LO_MASK  = 8'h7f;
	localparam logic [7:0]  TYPE_ON     = 8'h90;
	localparam logic [7:0]  TYPE_OFF    = 8'h80;
	localparam logic [7:0]  TYPE_MASK   = 8'hf0;
	localparam logic [7:0]  CHAN_MASK   = 8'h0f;
	localparam logic [7:0]  FORCED_VEL  = 8'h80;
	localparam logic [4:0]  MAX_OUT     = 5'd16;

	typedef struct packed {
		logic        kind;
		logic        first_in_packet;
		logic [7:0]  header_byte;
		logic [7:0]  ts_low_byte;
		logic [7:0]  status_byte;
		logic [7:0]  key_number;
		logic [7:0]  velocity;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_status;
		logic [7:0]  out_key;
		logic [7:0]  out_velocity;
		logic [15:0] delay_ms;
		logic        forced;
		logic        table_full;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  key;
		logic [3:0]  channel;
		logic [31:0] start;
	} note_entry_t;

	typedef struct packed {
		logic hit;
		logic expired;
	} cmp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_APP,
		ST_EVT,
		ST_FIN
	} state_t;

endpackage

/* src/ble_mnt_ts.sv */
// Running BLE-MIDI timestamp and delay since the packet's first event.
module ble_mnt_ts (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd,
	input  logic        first,
	input  logic [7:0]  header,
	input  logic [7:0]  ts_low,
	output logic [15:0] delay
);

	logic [7:0]  ts_high_q;
	logic [6:0]  low_prev_q;
	logic [15:0] pkt_start_q;
	logic [7:0]  hi_n;
	logic [6:0]  low;
	logic [15:0] t1;
	logic [15:0] start_n;

	always_comb begin
		low = ts_low[6:0] & ble_mnt_pkg::TS_LO_MASK[6:0];
		if (first) begin
			hi_n = header & ble_mnt_pkg::TS_HI_MASK;
		end else if (low < low_prev_q) begin
			hi_n = ts_high_q + 8'd1;
		end else begin
			hi_n = ts_high_q;
		end
		t1      = {1'b0, hi_n, low};
		start_n = first ? t1 : pkt_start_q;
		delay   = t1 - start_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_high_q   <= '0;
			low_prev_q  <= '0;
			pkt_start_q <= '0;
		end else if (upd) begin
			ts_high_q   <= hi_n;
			low_prev_q  <= low;
			pkt_start_q <= start_n;
		end
	end

endmodule

/* src/ble_mnt_cmp.sv */
// Shared compare unit: key/channel match and age check of one table entry.
module ble_mnt_cmp (
	input  ble_mnt_pkg::note_entry_t entry,
	input  logic [7:0]               key,
	input  logic [3:0]               channel,
	input  logic [31:0]              now,
	input  logic [15:0]              timeout,
	output ble_mnt_pkg::cmp_t        res
);

	logic [31:0] age;

	always_comb begin
		age         = now - entry.start;
		res.hit     = (entry.key == key) && (entry.channel == channel);
		res.expired = age > {16'd0, timeout};
	end

endmodule

/* src/ble_midi_note_tracker_core.sv */
// Top level: note table memory, scan sequencer and result staging.
// An item walks the table entry by entry, each entry a registered memory read (ST_RD) then a
// compare (ST_CHK) that stalls while a forced note-off cannot be staged; an event then passes
// ST_APP, ST_EVT and ST_FIN, a tick only ST_FIN; the next item is taken once the last result
// reaches the output register. Throughput is set by the single compare unit scanning the table entry by entry.
// Reset clears timestamp state and the note count and sets the timeout to 5000 ms; the table
// is never cleared, since entries past the count are never read.
module ble_midi_note_tracker_core #(
	parameter int MAX_NOTES = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ble_mnt_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ble_mnt_pkg::out_item_t out_data,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata
);

	localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int CNT_W = $clog2(MAX_NOTES + 1);

	ble_mnt_pkg::state_t      state_q, state_d;
	ble_mnt_pkg::in_item_t    in_q;
	ble_mnt_pkg::note_entry_t mem [MAX_NOTES];
	ble_mnt_pkg::note_entry_t rdata_q, new_ent;
	ble_mnt_pkg::out_item_t   pend_q, out_q, push_r, last_r;
	ble_mnt_pkg::cmp_t        cmp;
	logic                     pend_v_q, out_v_q;
	logic [15:0]              timeout_q, delay_q, delay_w;
	logic [CNT_W-1:0]         rd_q, wr_q, cnt_q;
	logic [4:0]               nemit_q;
	logic                     full_q;
	logic                     accept, out_free, is_on, is_off, drop, emit_off;
	logic                     push, flush, keep, scan_end;
	logic [7:0]               ev_type;
	logic [3:0]               ev_ch;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ble_mnt_pkg::ST_IDLE);
	assign out_free = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign out_data  = out_q;
	assign ev_type  = in_q.status_byte & ble_mnt_pkg::TYPE_MASK;
	assign ev_ch    = in_q.status_byte[3:0] & ble_mnt_pkg::CHAN_MASK[3:0];
	assign is_on    = (ev_type == ble_mnt_pkg::TYPE_ON) && (in_q.velocity != 8'd0);
	assign is_off   = (ev_type == ble_mnt_pkg::TYPE_OFF) || (ev_type == ble_mnt_pkg::TYPE_ON);
	assign scan_end = (rd_q + CNT_W'(1)) == cnt_q;

	ble_mnt_ts u_ts (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (accept && !in_data.kind),
		.first  (in_data.first_in_packet),
		.header (in_data.header_byte),
		.ts_low (in_data.ts_low_byte),
		.delay  (delay_w)
	);

	ble_mnt_cmp u_cmp (
		.entry   (rdata_q),
		.key     (in_q.key_number),
		.channel (ev_ch),
		.now     (in_q.now_ms),
		.timeout (timeout_q),
		.res     (cmp)
	);

	always_comb begin
		new_ent.key     = in_q.key_number;
		new_ent.channel = ev_ch;
		new_ent.start   = in_q.now_ms;
		if (in_q.kind) begin
			drop = cmp.expired && (nemit_q < ble_mnt_pkg::MAX_OUT);
		end else begin
			drop = is_off && cmp.hit;
		end
		// a plain note-off removes its entry silently
		emit_off = drop && (in_q.kind || is_on);
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		flush   = 1'b0;
		keep    = 1'b0;
		push_r  = '0;
		case (state_q)
			ble_mnt_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (cnt_q != '0) begin
						state_d = ble_mnt_pkg::ST_RD;
					end else begin
						state_d = in_data.kind ? ble_mnt_pkg::ST_FIN : ble_mnt_pkg::ST_APP;
					end
				end
			end
			ble_mnt_pkg::ST_RD: begin
				state_d = ble_mnt_pkg::ST_CHK;
			end
			ble_mnt_pkg::ST_CHK: begin
				push_r.out_status   = ble_mnt_pkg::TYPE_OFF | {4'd0, rdata_q.channel};
				push_r.out_key      = rdata_q.key;
				push_r.out_velocity = ble_mnt_pkg::FORCED_VEL;
				push_r.forced       = 1'b1;
				// hold the entry until the staging register can take the note-off
				if (!(emit_off && !out_free)) begin
					push = emit_off;
					keep = !drop;
					if (scan_end) begin
						state_d = in_q.kind ? ble_mnt_pkg::ST_FIN : ble_mnt_pkg::ST_APP;
					end else begin
						state_d = ble_mnt_pkg::ST_RD;
					end
				end
			end
			ble_mnt_pkg::ST_APP: begin
				state_d = ble_mnt_pkg::ST_EVT;
			end
			ble_mnt_pkg::ST_EVT: begin
				push_r.out_status   = in_q.status_byte;
				push_r.out_key      = in_q.key_number;
				push_r.out_velocity = in_q.velocity;
				push_r.delay_ms     = delay_q;
				push_r.table_full   = full_q;
				if (out_free) begin
					push    = 1'b1;
					state_d = ble_mnt_pkg::ST_FIN;
				end
			end
			ble_mnt_pkg::ST_FIN: begin
				if (!pend_v_q) begin
					state_d = ble_mnt_pkg::ST_IDLE;
				end else if (out_free) begin
					flush   = 1'b1;
					state_d = ble_mnt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ble_mnt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		last_r      = pend_q;
		last_r.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ble_mnt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ble_mnt_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ble_mnt_pkg::ST_RD) begin
			rdata_q <= mem[rd_q[IDX_W-1:0]];
		end
		if (keep) begin
			mem[wr_q[IDX_W-1:0]] <= rdata_q;
		end else if (state_q == ble_mnt_pkg::ST_APP && is_on && cnt_q < CNT_W'(MAX_NOTES)) begin
			mem[cnt_q[IDX_W-1:0]] <= new_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q    <= in_data;
			delay_q <= delay_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			cnt_q   <= '0;
			nemit_q <= '0;
			full_q  <= 1'b0;
		end else begin
			if (accept) begin
				rd_q    <= '0;
				wr_q    <= '0;
				nemit_q <= '0;
				full_q  <= 1'b0;
			end
			if (state_q == ble_mnt_pkg::ST_CHK && !(emit_off && !out_free)) begin
				rd_q <= rd_q + CNT_W'(1);
				if (keep) begin
					wr_q <= wr_q + CNT_W'(1);
				end
				if (push) begin
					nemit_q <= nemit_q + 5'd1;
				end
				// compact: survivors are packed down to the new count
				if (scan_end) begin
					cnt_q <= wr_q + CNT_W'(keep);
				end
			end
			if (state_q == ble_mnt_pkg::ST_APP && is_on) begin
				if (cnt_q < CNT_W'(MAX_NOTES)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					full_q <= 1'b1;
				end
			end
		end
	end

	// Pending result waits until it is known whether it is the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end else if (out_ready) begin
					out_v_q <= 1'b0;
				end
			end else if (flush) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= push_r;
			if (pend_v_q) begin
				out_q <= pend_q;
			end
		end else if (flush) begin
			out_q <= last_r;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_NOTES))
		else $error("note count past table size");

	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nemit_q <= ble_mnt_pkg::MAX_OUT)
		else $error("more forced note-offs than allowed");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ble_mnt_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("result left pending while idle");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ble_mnt_pkg::ST_CHK) |-> (wr_q <= rd_q))
		else $error("compaction write ahead of read");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> (out_v_q && out_q.last))
		else $error("final result not marked last");

endmodule
